// File: design/stk_pkg.sv
// Package for the streaming top-k selector: beat structs, entry type and constants.
// Used by stk_cell, stk_drain and streaming_top_k_selector_top; depends on nothing.
package stk_pkg;

    localparam int K_MAX_DEF  = 16;
    localparam int MAX_SCORES = 65536;
    localparam int POS_W      = 16;
    localparam int SCORE_W    = 8;
    localparam int RANK_W     = 4;
    localparam int KEEP_W     = 5;
    localparam int POS_LIMIT_I = (MAX_SCORES - 1 > 65535) ? 65535 : (MAX_SCORES - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last_score;
    } t_in_beat;

    typedef struct packed {
        logic [POS_W-1:0]   doc_position;
        logic [SCORE_W-1:0] best_score;
        logic [RANK_W-1:0]  rank;
        logic               last_result;
    } t_out_beat;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   pos;
    } t_entry;

endpackage

// File: design/stk_cell.sv
// One slot of the sorted insertion chain: holds a score and its position.
// Depends on stk_pkg for t_entry.
module stk_cell
    import stk_pkg::*;
(
    input  logic   i_clk,
    input  t_entry i_new,
    input  t_entry i_prev,
    input  logic   i_prev_lt,
    input  logic   i_valid,
    input  logic   i_insert,
    input  logic   i_en,
    output t_entry o_entry,
    output t_entry o_next,
    output logic   o_lt
);

    t_entry r_entry;
    t_entry n_entry;

    // The new score ranks below every valid entry with an equal or higher score.
    assign o_lt = !(i_valid && (r_entry.score >= i_new.score));

    always_comb begin
        n_entry = r_entry;
        if (i_insert) begin
            if (i_prev_lt) begin
                n_entry = i_prev;
            end else if (o_lt) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// File: design/stk_drain.sv
// Result buffer: a shift line loaded with a finished list, emitted one beat per entry.
// Depends on stk_pkg for t_entry and t_out_beat.
module stk_drain
    import stk_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  t_entry [K_MAX-1:0]            i_load_entries,
    input  logic [$clog2(K_MAX+1)-1:0]    i_load_count,
    input  logic                          i_ready,
    output logic                          o_valid,
    output t_out_beat                     o_data,
    output logic                          o_free
);

    localparam int KW = $clog2(K_MAX + 1);
    localparam int RW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    t_entry [K_MAX-1:0] r_buf;
    logic [KW-1:0]      r_left;
    logic [RW-1:0]      r_rank;
    logic [RW+RANK_W-1:0] rank_ext;
    logic               pop;

    assign o_valid = (r_left != '0);
    assign o_free  = (r_left == '0) || ((r_left == KW'(1)) && i_ready);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_load_entries;
        end else if (pop) begin
            for (int j = 0; j < K_MAX - 1; j++) begin
                r_buf[j] <= r_buf[j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_left <= i_load_count;
            r_rank <= '0;
        end else if (pop) begin
            r_left <= r_left - KW'(1);
            r_rank <= r_rank + RW'(1);
        end
    end

    assign rank_ext = {{RANK_W{1'b0}}, r_rank};

    always_comb begin
        o_data.doc_position = r_buf[0].pos;
        o_data.best_score   = r_buf[0].score;
        o_data.rank         = rank_ext[RANK_W-1:0];
        o_data.last_result  = (r_left == KW'(1));
    end

endmodule

// File: design/streaming_top_k_selector_top.sv
// Top level of the streaming top-k selector: insertion chain of stk_cell plus stk_drain.
// Depends on stk_pkg, stk_cell and stk_drain.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------
//   in      | input     | i_in_valid / o_in_ready   | t_in_beat
//   out     | output    | o_out_valid / i_out_ready | t_out_beat
//   cfg     | input     | i_cfg_we                  | keep_count
//
// A score beat is taken every cycle unless it is a closing beat that has to wait, and all kept
// entries compare against it in parallel. The beat that closes a list loads the result buffer,
// which emits one beat per cycle while i_out_ready is high, the first in the cycle after the closing beat.
// A closing beat waits while an earlier list has beats left to send, bar a final beat taken in that cycle.
// Reset empties the chain and the buffer and sets keep_count to 16.
module streaming_top_k_selector_top
    import stk_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_we,
    input  logic [KEEP_W-1:0] i_cfg_wdata
);

    localparam int KW = $clog2(K_MAX + 1);

    logic [KEEP_W-1:0]  r_keep_count;
    logic [KW-1:0]      r_count;
    logic [KW-1:0]      n_count;
    logic [POS_W-1:0]   r_next_pos;
    logic [KW-1:0]      eff_k;
    logic [KW-1:0]      out_count;
    logic [K_MAX-1:0]   lt_vec;
    logic [K_MAX-1:0]   valid_vec;
    logic               accept;
    logic               insert;
    logic               drain_free;
    t_entry             new_entry;
    t_entry [K_MAX-1:0] cur_entries;
    t_entry [K_MAX-1:0] next_entries;

    always_comb begin
        if (r_keep_count == '0) begin
            eff_k = KW'(1);
        end else if (32'(r_keep_count) > K_MAX) begin
            eff_k = KW'(K_MAX);
        end else begin
            eff_k = KW'(r_keep_count);
        end
    end

    assign o_in_ready = !i_in_data.last_score || drain_free;
    assign accept     = i_in_valid && o_in_ready;

    assign new_entry.score = i_in_data.score;
    assign new_entry.pos   = r_next_pos;

    assign insert = (r_count < eff_k) || ((lt_vec & valid_vec) != '0);

    for (genvar i = 0; i < K_MAX; i++) begin : g_cell
        assign valid_vec[i] = (32'(r_count) > i);
        stk_cell u_cell (
            .i_clk     (i_clk),
            .i_new     (new_entry),
            .i_prev    ((i == 0) ? new_entry : cur_entries[(i == 0) ? 0 : i-1]),
            .i_prev_lt ((i == 0) ? 1'b0 : lt_vec[(i == 0) ? 0 : i-1]),
            .i_valid   (valid_vec[i]),
            .i_insert  (insert),
            .i_en      (accept),
            .o_entry   (cur_entries[i]),
            .o_next    (next_entries[i]),
            .o_lt      (lt_vec[i])
        );
    end

    assign n_count   = (r_count < eff_k) ? (r_count + KW'(1)) : r_count;
    assign out_count = (n_count > eff_k) ? eff_k : n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_next_pos <= '0;
        end else if (accept) begin
            if (i_in_data.last_score) begin
                r_count    <= '0;
                r_next_pos <= '0;
            end else begin
                r_count <= n_count;
                if (r_next_pos < POS_LIMIT) begin
                    r_next_pos <= r_next_pos + POS_W'(1);
                end
            end
        end
    end

    stk_drain #(
        .K_MAX (K_MAX)
    ) u_drain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && i_in_data.last_score),
        .i_load_entries (next_entries),
        .i_load_count   (out_count),
        .i_ready        (i_out_ready),
        .o_valid        (o_out_valid),
        .o_data         (o_out_data),
        .o_free         (drain_free)
    );

endmodule

// File: test/streaming_top_k_selector_top_checker.sv
// Scoreboard for the streaming top-k selector: follows score beats and keep_count writes,
// predicts the ranked result beats of every list and compares each accepted result beat.
// Depends on stk_pkg.
module streaming_top_k_selector_top_checker
    import stk_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_beat          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_beat         i_out_data,
    input  logic              i_cfg_we,
    input  logic [KEEP_W-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_fail_count
);

    logic [SCORE_W-1:0] held_score [K_MAX];
    logic [POS_W-1:0]   held_pos [K_MAX];
    int                 held_count = 0;
    logic [POS_W-1:0]   next_pos = '0;
    logic [KEEP_W-1:0]  keep_count = KEEP_RESET;
    t_out_beat          ranked_q [$];
    int                 mismatches = 0;

    function automatic int clamp_keep(input logic [KEEP_W-1:0] value);
        if (value == '0) return 1;
        if (int'(value) > K_MAX) return K_MAX;
        return int'(value);
    endfunction

    task automatic rank_score(input t_in_beat beat);
        int        k;
        int        slot;
        int        tail;
        int        n;
        int        i;
        t_out_beat res;
        k    = clamp_keep(keep_count);
        slot = 0;
        while (slot < held_count && held_score[slot] >= beat.score) slot++;
        tail = -1;
        if (held_count < k) begin
            tail = held_count;
            held_count++;
        end else if (held_count > 0 && slot < held_count) begin
            // The new score strictly beats the smallest held entry, which falls out.
            tail = held_count - 1;
        end
        if (tail >= 0) begin
            for (i = tail; i > slot; i--) begin
                held_score[i] = held_score[i-1];
                held_pos[i]   = held_pos[i-1];
            end
            held_score[slot] = beat.score;
            held_pos[slot]   = next_pos;
        end
        if (next_pos < POS_LIMIT) next_pos++;
        if (beat.last_score) begin
            n = (held_count < k) ? held_count : k;
            for (i = 0; i < n; i++) begin
                res.doc_position = held_pos[i];
                res.best_score   = held_score[i];
                res.rank         = RANK_W'(i);
                res.last_result  = (i == n - 1);
                ranked_q = {ranked_q, res};
            end
            held_count = 0;
            next_pos   = '0;
        end
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        if (ranked_q.size() == 0) begin
            $error("unexpected result beat: doc_position %0d, best_score %0d",
                   got.doc_position, got.best_score);
            mismatches++;
            return;
        end
        want = ranked_q.pop_front();
        if (got.doc_position !== want.doc_position) begin
            $error("doc_position: expected %0d, actual %0d", want.doc_position, got.doc_position);
            mismatches++;
        end
        if (got.best_score !== want.best_score) begin
            $error("best_score: expected %0d, actual %0d", want.best_score, got.best_score);
            mismatches++;
        end
        if (got.rank !== want.rank) begin
            $error("rank: expected %0d, actual %0d", want.rank, got.rank);
            mismatches++;
        end
        if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, actual %0d", want.last_result, got.last_result);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            keep_count = KEEP_RESET;
            held_count = 0;
            next_pos   = '0;
            ranked_q.delete();
        end else begin
            if (i_cfg_we) keep_count = i_cfg_wdata;
            if (i_in_valid && i_in_ready) rank_score(i_in_data);
            if (i_out_valid && i_out_ready) check_result(i_out_data);
        end
        o_pending    <= ranked_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: test/streaming_top_k_selector_top_tb.sv
// Testbench top for the streaming top-k selector: clock, reset, score and keep_count stimulus,
// random idling on both channels and the verdict. Depends on stk_pkg, the block and
// streaming_top_k_selector_top_checker.
module streaming_top_k_selector_top_tb;
    import stk_pkg::*;

    localparam int K_MAX        = K_MAX_DEF;
    localparam int DRAIN_CYCLES = 2 * K_MAX + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 20;
    localparam int PHASES       = 8;
    localparam int TAIL_ITEMS   = 20;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_beat          in_data;
    logic              out_valid;
    logic              out_ready;
    t_out_beat         out_data;
    logic              cfg_we;
    logic [KEEP_W-1:0] cfg_wdata;
    logic              hold_req;
    logic              quiet;
    int                pending;
    int                fail_count;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    streaming_top_k_selector_top #(
        .K_MAX(K_MAX)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    streaming_top_k_selector_top_checker #(
        .K_MAX(K_MAX)
    ) scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    function automatic logic [SCORE_W-1:0] random_score(input logic narrow);
        int pick;
        pick = $urandom_range(0, 7);
        if (narrow) return SCORE_W'($urandom_range(0, 3));
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return SCORE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_score(input logic [SCORE_W-1:0] score, input logic last);
        t_in_beat beat;
        beat.score      = score;
        beat.last_score = last;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_keep(input logic [KEEP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int                 idle_left;
        logic               hold_done;
        idle_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else if (quiet) begin
                out_ready <= 1'b1;
            end else if (idle_left > 0) begin
                out_ready <= 1'b0;
                idle_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                idle_left = $urandom_range(0, 16);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int                 span;
        int                 ph;
        int                 n;
        logic               last;
        logic [KEEP_W-1:0]  keep_val;
        logic [SCORE_W-1:0] score;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        hold_req  <= 1'b0;
        quiet     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_score(8'd0, 1'b1);
        send_score(8'd255, 1'b0);
        send_score(8'd0, 1'b0);
        send_score(8'd255, 1'b0);
        send_score(8'd128, 1'b1);

        settle();
        set_keep(5'd0);
        send_score(8'd5, 1'b0);
        send_score(8'd9, 1'b0);
        send_score(8'd9, 1'b1);

        // A list that is open while keep_count drops below the number of held entries.
        settle();
        set_keep(5'd31);
        send_score(8'd10, 1'b0);
        send_score(8'd20, 1'b0);
        send_score(8'd20, 1'b0);
        send_score(8'd30, 1'b0);
        send_score(8'd5, 1'b0);
        send_score(8'd20, 1'b0);
        settle();
        set_keep(5'd2);
        send_score(8'd20, 1'b0);
        send_score(8'd255, 1'b1);

        settle();
        set_keep(5'd1);
        send_score(8'd255, 1'b0);
        send_score(8'd255, 1'b1);

        // Lists run across phase boundaries, so keep_count also changes inside open lists.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       keep_val = 5'd1;
                1:       keep_val = 5'd31;
                2:       keep_val = 5'd4;
                3:       keep_val = 5'd0;
                4:       keep_val = 5'd17;
                5:       keep_val = KEEP_W'($urandom_range(1, 16));
                6:       keep_val = KEEP_W'($urandom_range(0, 31));
                default: keep_val = 5'd16;
            endcase
            settle();
            set_keep(keep_val);
            span = (ph == 2) ? 2 : $urandom_range(0, 24);
            if (ph == 2) hold_req <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 5) == 0) pause_input($urandom_range(1, 17));
                last = ($urandom_range(0, span) == 0) ||
                       (ph == PHASES - 1 && n == PHASE_ITEMS - 1);
                send_score(random_score((ph % 2) == 1), last);
            end
        end

        // A final list sent without any idling on either side.
        settle();
        set_keep(KEEP_W'(K_MAX));
        quiet <= 1'b1;
        for (n = 0; n < TAIL_ITEMS; n++) begin
            score = random_score(1'b0);
            send_score(score, n == TAIL_ITEMS - 1);
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("streaming_top_k_selector_top_tb passed");
        end else begin
            $display("streaming_top_k_selector_top_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("streaming_top_k_selector_top_tb failed");
        $finish;
    end

endmodule

// File: sim.f
design/stk_pkg.sv
design/stk_cell.sv
design/stk_drain.sv
design/streaming_top_k_selector_top.sv
test/streaming_top_k_selector_top_checker.sv
test/streaming_top_k_selector_top_tb.sv
